FILE: design/rhp_pkg.sv
// shared types and constants for the rtp header parser
`default_nettype none
package rhp_pkg;

   localparam logic [15:0] FIXED_HDR        = 16'd12;
   localparam logic [15:0] MAX_PACKET_BYTES = 16'hFFFF;
   localparam logic [15:0] HDR_END_LIMIT    = 16'hFFFF;
   localparam logic [1:0]  VERSION_RESET    = 2'd2;
   localparam int          QUEUE_DEPTH      = 2;
   localparam int          QPTR_W           = $clog2(QUEUE_DEPTH);
   localparam int          QCNT_W           = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_TRUNC  = 2'd1,
      ST_BADVER = 2'd2,
      ST_BADPAD = 2'd3
   } status_type;

   // header summary of one finished packet
   typedef struct packed {
      logic [15:0] first_hw;
      logic [15:0] seq;
      logic [31:0] time_stamp;
      logic [31:0] ssrc;
      logic [15:0] hdr_end;
      logic [15:0] pkt_len;
      logic        oversize;
      logic [7:0]  final_byte;
   } pkt_rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage
`default_nettype wire

FILE: design/rhp_front.sv
// byte-side capture of rtp header fields, one summary record per packet
`default_nettype none
module rhp_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   accept,
   input  wire  [7:0]            data_byte,
   input  wire                   last_byte,
   output logic                  push,
   output rhp_pkg::pkt_rec_type  rec
);

   logic [15:0] pos_ff, pos_in;
   logic [15:0] hw_ff, hw_in;
   logic [15:0] seq_ff, seq_in;
   logic [31:0] time_ff, time_in;
   logic [31:0] ssrc_ff, ssrc_in;
   logic [15:0] hend_ff, hend_in;
   logic [7:0]  prev_ff, prev_in;

   logic [15:0] cap_pos, cap_hw, cap_seq, cap_hend;
   logic [31:0] cap_time, cap_ssrc;
   logic [7:0]  cap_prev;
   logic        room;
   logic [6:0]  csrc_base;
   logic [18:0] ext_sum;

   assign room      = (pos_ff != rhp_pkg::MAX_PACKET_BYTES);
   assign csrc_base = 7'(rhp_pkg::FIXED_HDR) + {1'b0, hw_ff[11:8], 2'b00};
   assign ext_sum   = 19'(csrc_base) + 19'd4 + {1'b0, prev_ff, data_byte, 2'b00};

   always_comb begin
      cap_pos  = pos_ff;
      cap_hw   = hw_ff;
      cap_seq  = seq_ff;
      cap_time = time_ff;
      cap_ssrc = ssrc_ff;
      cap_hend = hend_ff;
      cap_prev = prev_ff;
      if (accept && room) begin
         cap_pos = pos_ff + 16'd1;
         if (pos_ff == 16'd0) begin
            cap_hw   = {data_byte, 8'h00};
            cap_hend = rhp_pkg::FIXED_HDR + {10'd0, data_byte[3:0], 2'b00};
         end else if (pos_ff == 16'd1) begin
            cap_hw = {hw_ff[15:8], data_byte};
         end else if (pos_ff < 16'd4) begin
            cap_seq = {seq_ff[7:0], data_byte};
         end else if (pos_ff < 16'd8) begin
            cap_time = {time_ff[23:0], data_byte};
         end else if (pos_ff < 16'd12) begin
            cap_ssrc = {ssrc_ff[23:0], data_byte};
         end
         // extension length sits in the first word after the csrc list
         if (pos_ff >= 16'd2 && hw_ff[12]) begin
            if (pos_ff == 16'(csrc_base) + 16'd2) begin
               cap_prev = data_byte;
            end else if (pos_ff == 16'(csrc_base) + 16'd3) begin
               cap_hend = (ext_sum > 19'(rhp_pkg::HDR_END_LIMIT)) ?
                          rhp_pkg::HDR_END_LIMIT : ext_sum[15:0];
            end
         end
      end
   end

   always_comb begin
      push = accept && last_byte;
      rec.first_hw   = cap_hw;
      rec.seq        = cap_seq;
      rec.time_stamp = cap_time;
      rec.ssrc       = cap_ssrc;
      rec.hdr_end    = cap_hend;
      rec.pkt_len    = cap_pos;
      rec.oversize   = !room;
      rec.final_byte = data_byte;
   end

   always_comb begin
      if (push) begin
         pos_in  = 16'd0;
         hw_in   = 16'd0;
         seq_in  = 16'd0;
         time_in = 32'd0;
         ssrc_in = 32'd0;
         hend_in = rhp_pkg::FIXED_HDR;
         prev_in = 8'd0;
      end else begin
         pos_in  = cap_pos;
         hw_in   = cap_hw;
         seq_in  = cap_seq;
         time_in = cap_time;
         ssrc_in = cap_ssrc;
         hend_in = cap_hend;
         prev_in = cap_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 16'd0;
         hw_ff   <= 16'd0;
         seq_ff  <= 16'd0;
         time_ff <= 32'd0;
         ssrc_ff <= 32'd0;
         hend_ff <= rhp_pkg::FIXED_HDR;
         prev_ff <= 8'd0;
      end else begin
         pos_ff  <= pos_in;
         hw_ff   <= hw_in;
         seq_ff  <= seq_in;
         time_ff <= time_in;
         ssrc_ff <= ssrc_in;
         hend_ff <= hend_in;
         prev_ff <= prev_in;
      end
   end

   // a fresh packet always starts at the fixed header end
   a_hend_floor: assert property (@(posedge clock) disable iff (reset)
      hend_ff >= rhp_pkg::FIXED_HDR)
      else $error("header end below fixed header");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      push |=> (pos_ff == 16'd0 && hw_ff == 16'd0))
      else $error("packet state not cleared after last byte");

endmodule
`default_nettype wire

FILE: design/rhp_queue.sv
// short fifo of packet summaries between byte capture and result stage
`default_nettype none
module rhp_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  rhp_pkg::pkt_rec_type  push_rec,
   input  wire                   pop,
   output rhp_pkg::pkt_rec_type  head_rec,
   output rhp_pkg::q_status_type q_status
);

   rhp_pkg::pkt_rec_type entries_ff [rhp_pkg::QUEUE_DEPTH];

   logic [rhp_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rhp_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rhp_pkg::QCNT_W-1:0] count_ff, count_in;

   function automatic logic [rhp_pkg::QPTR_W-1:0] ptr_next(
      input logic [rhp_pkg::QPTR_W-1:0] ptr);
      ptr_next = (32'(ptr) == rhp_pkg::QUEUE_DEPTH - 1) ?
                 '0 : ptr + rhp_pkg::QPTR_W'(1);
   endfunction

   assign q_status.full  = (32'(count_ff) == rhp_pkg::QUEUE_DEPTH);
   assign q_status.empty = (count_ff == '0);
   assign head_rec       = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + rhp_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - rhp_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

endmodule
`default_nettype wire

FILE: design/rhp_back.sv
// packet checks, padding removal and registered result stage
`default_nettype none
module rhp_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire  [1:0]            expected_version,
   input  rhp_pkg::pkt_rec_type  head_rec,
   input  rhp_pkg::q_status_type q_status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic [1:0]            rsp_status,
   output logic [6:0]            rsp_pt_code,
   output logic                  rsp_marker,
   output logic [15:0]           rsp_sequence_res,
   output logic [31:0]           rsp_timestamp,
   output logic [31:0]           rsp_source_id,
   output logic [3:0]            rsp_csrc_count,
   output logic                  rsp_extension_present,
   output logic [7:0]            rsp_padding_count,
   output logic [15:0]           rsp_payload_offset,
   output logic [15:0]           rsp_trimmed_length
);

   logic                   valid_ff, valid_in;
   rhp_pkg::status_type    status_ff, status_in;
   logic [15:0]            hw_ff;
   logic [15:0]            seq_ff;
   logic [31:0]            time_ff;
   logic [31:0]            ssrc_ff;
   logic [7:0]             pad_ff, pad_in;
   logic [15:0]            offset_ff, offset_in;
   logic [15:0]            trimmed_ff, trimmed_in;

   logic [15:0] csrc_base;
   logic [15:0] len;
   logic [15:0] hend;
   logic [15:0] pad_wide;

   assign len       = head_rec.pkt_len;
   assign hend      = head_rec.hdr_end;
   assign pad_wide  = {8'd0, head_rec.final_byte};
   assign csrc_base = rhp_pkg::FIXED_HDR + {10'd0, head_rec.first_hw[11:8], 2'b00};

   assign pop      = !q_status.empty && (!valid_ff || !rsp_stall);
   assign valid_in = pop ? 1'b1 : (valid_ff && rsp_stall);

   always_comb begin
      status_in  = rhp_pkg::ST_OK;
      pad_in     = 8'd0;
      offset_in  = 16'd0;
      trimmed_in = len;
      if (head_rec.oversize || len < rhp_pkg::FIXED_HDR) begin
         status_in = rhp_pkg::ST_TRUNC;
      end else if (head_rec.first_hw[15:14] != expected_version) begin
         status_in = rhp_pkg::ST_BADVER;
      end else if ((head_rec.first_hw[12] && len < csrc_base + 16'd4) ||
                   len < hend || hend == rhp_pkg::HDR_END_LIMIT) begin
         status_in = rhp_pkg::ST_TRUNC;
      end else begin
         offset_in = hend;
         if (head_rec.first_hw[13]) begin
            pad_in = head_rec.final_byte;
            // padding must leave at least one byte past the fixed header
            if (pad_wide != 16'd0 && pad_wide < len - rhp_pkg::FIXED_HDR) begin
               trimmed_in = len - pad_wide;
            end else begin
               status_in = rhp_pkg::ST_BADPAD;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff  <= status_in;
         hw_ff      <= head_rec.first_hw;
         seq_ff     <= head_rec.seq;
         time_ff    <= head_rec.time_stamp;
         ssrc_ff    <= head_rec.ssrc;
         pad_ff     <= pad_in;
         offset_ff  <= offset_in;
         trimmed_ff <= trimmed_in;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_pt_code           = hw_ff[6:0];
   assign rsp_marker            = hw_ff[7];
   assign rsp_sequence_res      = seq_ff;
   assign rsp_timestamp         = time_ff;
   assign rsp_source_id         = ssrc_ff;
   assign rsp_csrc_count        = hw_ff[11:8];
   assign rsp_extension_present = hw_ff[12];
   assign rsp_padding_count     = pad_ff;
   assign rsp_payload_offset    = offset_ff;
   assign rsp_trimmed_length    = trimmed_ff;

   a_err_no_offset: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (status_ff == rhp_pkg::ST_TRUNC || status_ff == rhp_pkg::ST_BADVER)
      |-> (offset_ff == 16'd0 && pad_ff == 8'd0))
      else $error("error result carries offset or padding");

endmodule
`default_nettype wire

FILE: design/rtp_header_parser.sv
// rtp header parser top level: byte capture, summary queue, result stage
//
//  channel | ports                      | direction | moves
//  --------+----------------------------+-----------+------------------------------
//  req     | req_valid / req_stall      | in        | one packet byte per request
//  rsp     | rsp_valid / rsp_stall      | out       | one header result per packet
//  csr     | csr_wr_en / csr_wr_data    | in        | expected version register
//
//  one byte per cycle while req_stall is low; a packet's summary is registered in the summary queue
//  after its last byte, then its result in the output register
//  the byte counter and header captures set the per-byte path; checks run at queue exit
//  reset is synchronous, active high; expected version comes up as 2
//  req_stall rises only when the summary queue is full, i.e. rsp has been stalled
//  over several packets
`default_nettype none
module rtp_header_parser (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_last_byte,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_pt_code,
   output logic        rsp_marker,
   output logic [15:0] rsp_sequence_res,
   output logic [31:0] rsp_timestamp,
   output logic [31:0] rsp_source_id,
   output logic [3:0]  rsp_csrc_count,
   output logic        rsp_extension_present,
   output logic [7:0]  rsp_padding_count,
   output logic [15:0] rsp_payload_offset,
   output logic [15:0] rsp_trimmed_length,
   input  wire         csr_wr_en,
   input  wire  [1:0]  csr_wr_data
);

   logic [1:0] version_ff, version_in;

   logic                  accept;
   logic                  push;
   logic                  pop;
   rhp_pkg::pkt_rec_type  push_rec;
   rhp_pkg::pkt_rec_type  head_rec;
   rhp_pkg::q_status_type q_status;

   assign req_stall  = q_status.full;
   assign accept     = req_valid && !req_stall;
   assign version_in = csr_wr_en ? csr_wr_data : version_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= rhp_pkg::VERSION_RESET;
      end else begin
         version_ff <= version_in;
      end
   end

   rhp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .push      (push),
      .rec       (push_rec)
   );

   rhp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .q_status (q_status)
   );

   rhp_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .expected_version      (version_ff),
      .head_rec              (head_rec),
      .q_status              (q_status),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_pt_code           (rsp_pt_code),
      .rsp_marker            (rsp_marker),
      .rsp_sequence_res      (rsp_sequence_res),
      .rsp_timestamp         (rsp_timestamp),
      .rsp_source_id         (rsp_source_id),
      .rsp_csrc_count        (rsp_csrc_count),
      .rsp_extension_present (rsp_extension_present),
      .rsp_padding_count     (rsp_padding_count),
      .rsp_payload_offset    (rsp_payload_offset),
      .rsp_trimmed_length    (rsp_trimmed_length)
   );

   // a request can only be refused while results are backing up
   a_stall_needs_backlog: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no result pending");

endmodule
`default_nettype wire
